>>> sv/ovha_pkg.sv
// ----------------------------------------------------------------------------
// ovha_pkg: shared types, constants and helpers of the overheat alarm
// Digit codes, BCD helpers and the word formats passed between units.
// ----------------------------------------------------------------------------
package ovha_pkg;

   localparam int CountWidth = 14;
   localparam int TempWidth  = 7;
   localparam int SegWidth   = 7;

   localparam logic [CountWidth-1:0] CountMax     = 14'd9999;
   localparam logic [CountWidth-1:0] DefaultReset = 14'd35;
   localparam logic [15:0]           DefaultResetBcd = 16'h0035;

   // floor(s * 488 / 1000) == floor(s * 61 / 125) == (s * 1023458) >> 21 for 8-bit s
   localparam int                 TempShift  = 21;
   localparam logic [19:0]        TempRecip  = 20'd1023458;

   typedef logic [3:0]            bcd_digit_type;
   typedef logic [3:0][3:0]       bcd4_type;

   // One scan, as held in the input register
   typedef struct packed {
      logic [TempWidth-1:0] temp;
      logic                 set_p;
      logic                 inc_p;
      logic                 dec_p;
      logic                 restore_p;
   } item_type;

   // Default setpoint as seen by the core
   typedef struct packed {
      logic [CountWidth-1:0] bin;
      bcd4_type              bcd;
      logic                  busy;
   } default_type;

   function automatic logic [SegWidth-1:0] seg_code(input bcd_digit_type d);
      logic [SegWidth-1:0] s;
      case (d)
         4'd0:    s = 7'h3f;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5b;
         4'd3:    s = 7'h4f;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6d;
         4'd6:    s = 7'h7d;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7f;
         4'd9:    s = 7'h6f;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   // Double-dabble correction of one digit
   function automatic bcd_digit_type add3(input bcd_digit_type d);
      bcd_digit_type r;
      r = (d >= 4'd5) ? d + 4'd3 : d;
      return r;
   endfunction

   function automatic bcd4_type dabble_adj(input bcd4_type v);
      bcd4_type r;
      for (int i = 0; i < 4; i++) begin
         r[i] = add3(v[i]);
      end
      return r;
   endfunction

   // Temperature (0..124) to three BCD digits, one bit per step
   function automatic bcd4_type temp_to_bcd(input logic [TempWidth-1:0] t);
      logic [11:0] b;
      bcd4_type    r;
      b = '0;
      for (int i = TempWidth - 1; i >= 0; i--) begin
         b = {add3(b[11:8]), add3(b[7:4]), add3(b[3:0])};
         b = {b[10:0], t[i]};
      end
      r = {4'd0, b};
      return r;
   endfunction

   function automatic bcd4_type bcd_inc(input bcd4_type v);
      bcd4_type r;
      logic     carry;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (carry) begin
            if (v[i] == 4'd9) begin
               r[i] = 4'd0;
            end else begin
               r[i]  = v[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic bcd4_type bcd_dec(input bcd4_type v);
      bcd4_type r;
      logic     borrow;
      r      = v;
      borrow = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (borrow) begin
            if (v[i] == 4'd0) begin
               r[i] = 4'd9;
            end else begin
               r[i]   = v[i] - 4'd1;
               borrow = 1'b0;
            end
         end
      end
      return r;
   endfunction

endpackage

>>> sv/ovha_csr.sv
// ----------------------------------------------------------------------------
// ovha_csr: default setpoint register
// Clamps the written value and converts it to BCD, one bit per cycle.
// ----------------------------------------------------------------------------
module ovha_csr
   import ovha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_default_setpoint,
   output default_type           dflt
);

   logic [CountWidth-1:0] bin_ff, bin_in;
   logic [CountWidth-1:0] shift_ff, shift_in;
   bcd4_type              bcd_ff, bcd_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   bcd4_type              adj;

   assign csr_ready = !busy_ff;
   assign adj       = dabble_adj(bcd_ff);

   always_comb begin
      bin_in   = bin_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (csr_valid && csr_ready) begin
         bin_in   = (csr_default_setpoint > CountMax) ? CountMax : csr_default_setpoint;
         shift_in = bin_in;
         bcd_in   = '0;
         cnt_in   = 4'(CountWidth);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift one binary bit into the BCD accumulator
         bcd_in   = {adj[3][2:0], adj[2], adj[1], adj[0], shift_ff[CountWidth-1]};
         shift_in = {shift_ff[CountWidth-2:0], 1'b0};
         cnt_in   = cnt_ff - 4'd1;
         busy_in  = (cnt_ff != 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff   <= DefaultReset;
         bcd_ff   <= DefaultResetBcd;
         shift_ff <= '0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         bin_ff   <= bin_in;
         bcd_ff   <= bcd_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
      end
   end

   assign dflt.bin  = bin_ff;
   assign dflt.bcd  = bcd_ff;
   assign dflt.busy = busy_ff;

endmodule

>>> sv/ovha_intake.sv
// ----------------------------------------------------------------------------
// ovha_intake: input register
// Scales the sample to a temperature and holds one scan for the core.
// ----------------------------------------------------------------------------
module ovha_intake
   import ovha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_adc_sample,
   input  logic       req_set_pressed,
   input  logic       req_inc_pressed,
   input  logic       req_dec_pressed,
   input  logic       req_restore_pressed,
   input  logic       hold,
   input  logic       take,
   output logic       item_valid,
   output item_type   item
);

   logic        valid_ff, valid_in;
   item_type    item_ff;
   logic [27:0] product;
   logic        accept;

   assign product   = {20'd0, req_adc_sample} * {8'd0, TempRecip};
   assign req_ready = (!valid_ff || take) && !hold;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.temp      <= product[TempShift +: TempWidth];
         item_ff.set_p     <= req_set_pressed;
         item_ff.inc_p     <= req_inc_pressed;
         item_ff.dec_p     <= req_dec_pressed;
         item_ff.restore_p <= req_restore_pressed;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> sv/ovha_core.sv
// ----------------------------------------------------------------------------
// ovha_core: mode state and result register
// Updates mode, setpoint, count and alarm per scan and registers the result.
// ----------------------------------------------------------------------------
module ovha_core
   import ovha_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  item_type            item,
   input  default_type         dflt,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SegWidth-1:0] rsp_seg_thousands,
   output logic [SegWidth-1:0] rsp_seg_hundreds,
   output logic [SegWidth-1:0] rsp_seg_tens,
   output logic [SegWidth-1:0] rsp_seg_units,
   output logic                rsp_buzzer_on,
   output logic                rsp_adjusting
);

   logic                  adjust_ff, adjust_in;
   logic                  alarm_ff, alarm_in;
   logic [CountWidth-1:0] setpoint_ff, setpoint_in;
   logic [CountWidth-1:0] count_ff, count_in;
   bcd4_type              count_bcd_ff, count_bcd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SegWidth-1:0]   seg_ff [4];
   bcd4_type              shown;

   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      adjust_in    = adjust_ff;
      alarm_in     = alarm_ff;
      setpoint_in  = setpoint_ff;
      count_in     = count_ff;
      count_bcd_in = count_bcd_ff;
      shown        = temp_to_bcd(item.temp);
      if (!adjust_ff) begin
         alarm_in = {{(CountWidth-TempWidth){1'b0}}, item.temp} >= setpoint_ff;
         if (item.set_p) begin
            adjust_in = 1'b1;
         end
      end else begin
         if (item.inc_p) begin
            if (count_ff < CountMax) begin
               count_in     = count_ff + 14'd1;
               count_bcd_in = bcd_inc(count_bcd_ff);
            end
         end else if (item.dec_p) begin
            if (count_ff != '0) begin
               count_in     = count_ff - 14'd1;
               count_bcd_in = bcd_dec(count_bcd_ff);
            end
         end else if (item.restore_p) begin
            setpoint_in  = dflt.bin;
            count_in     = dflt.bin;
            count_bcd_in = dflt.bcd;
         end
         shown = count_bcd_in;
         if (item.set_p) begin
            setpoint_in = count_in;
            adjust_in   = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adjust_ff    <= 1'b0;
         alarm_ff     <= 1'b0;
         setpoint_ff  <= DefaultReset;
         count_ff     <= DefaultReset;
         count_bcd_ff <= DefaultResetBcd;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            adjust_ff    <= adjust_in;
            alarm_ff     <= alarm_in;
            setpoint_ff  <= setpoint_in;
            count_ff     <= count_in;
            count_bcd_ff <= count_bcd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         seg_ff[0] <= seg_code(shown[3]);
         seg_ff[1] <= seg_code(shown[2]);
         seg_ff[2] <= seg_code(shown[1]);
         seg_ff[3] <= seg_code(shown[0]);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_seg_thousands = seg_ff[0];
   assign rsp_seg_hundreds  = seg_ff[1];
   assign rsp_seg_tens      = seg_ff[2];
   assign rsp_seg_units     = seg_ff[3];
   assign rsp_buzzer_on     = alarm_ff;
   assign rsp_adjusting     = adjust_ff;

endmodule

>>> sv/overheat_alarm_with_setpoint.sv
// ----------------------------------------------------------------------------
// overheat_alarm_with_setpoint: temperature alarm with adjustable setpoint
// Shows the scaled temperature or the edited setpoint on four seven-segment
// digits and drives the buzzer when the temperature reaches the setpoint.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_ready | sample and four button levels
//   rsp     | out       | rsp_valid / rsp_ready | four segment codes, buzzer, mode
//   csr     | in        | csr_valid / csr_ready | default setpoint (14 bits)
//
// On its way from req to rsp the sample is scaled into the
// input register, then mode, count and alarm update into the result register.
// One word per cycle is sustained while rsp_ready stays high and no csr write
// is converting; the result register frees the input side whenever rsp_ready is high or it is empty.
// A csr write keeps csr_ready and req_ready low while the value
// is converted to BCD, one bit per cycle. Reset is synchronous, active high,
// and loads the default setpoint 35.
// ----------------------------------------------------------------------------
module overheat_alarm_with_setpoint
   import ovha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // scan input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_adc_sample,
   input  logic                  req_set_pressed,
   input  logic                  req_inc_pressed,
   input  logic                  req_dec_pressed,
   input  logic                  req_restore_pressed,
   // display and alarm output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SegWidth-1:0]   rsp_seg_thousands,
   output logic [SegWidth-1:0]   rsp_seg_hundreds,
   output logic [SegWidth-1:0]   rsp_seg_tens,
   output logic [SegWidth-1:0]   rsp_seg_units,
   output logic                  rsp_buzzer_on,
   output logic                  rsp_adjusting,
   // default setpoint register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_default_setpoint
);

   default_type dflt;
   item_type    item;
   logic        item_valid;
   logic        take;

   // Hold the default and its BCD form; stall intake while converting
   ovha_csr u_csr (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_default_setpoint (csr_default_setpoint),
      .dflt                 (dflt)
   );

   // Scale the sample to degrees and register the scan
   ovha_intake u_intake (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_adc_sample      (req_adc_sample),
      .req_set_pressed     (req_set_pressed),
      .req_inc_pressed     (req_inc_pressed),
      .req_dec_pressed     (req_dec_pressed),
      .req_restore_pressed (req_restore_pressed),
      .hold                (dflt.busy),
      .take                (take),
      .item_valid          (item_valid),
      .item                (item)
   );

   // Advance the mode state and register the displayed word
   ovha_core u_core (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .dflt              (dflt),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_seg_thousands (rsp_seg_thousands),
      .rsp_seg_hundreds  (rsp_seg_hundreds),
      .rsp_seg_tens      (rsp_seg_tens),
      .rsp_seg_units     (rsp_seg_units),
      .rsp_buzzer_on     (rsp_buzzer_on),
      .rsp_adjusting     (rsp_adjusting)
   );

endmodule

>>> dv/overheat_alarm_with_setpoint_checker.sv
// ----------------------------------------------------------------------------
// overheat_alarm_with_setpoint_checker: scoreboard for the overheat alarm
// Watches the scan, display and default-setpoint channels. It predicts the
// display word of every accepted scan and compares it with the returned word.
// ----------------------------------------------------------------------------
module overheat_alarm_with_setpoint_checker
   import ovha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_adc_sample,
   input  logic                  req_set_pressed,
   input  logic                  req_inc_pressed,
   input  logic                  req_dec_pressed,
   input  logic                  req_restore_pressed,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SegWidth-1:0]   rsp_seg_thousands,
   input  logic [SegWidth-1:0]   rsp_seg_hundreds,
   input  logic [SegWidth-1:0]   rsp_seg_tens,
   input  logic [SegWidth-1:0]   rsp_seg_units,
   input  logic                  rsp_buzzer_on,
   input  logic                  rsp_adjusting,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_default_setpoint,
   output int                    mismatches,
   output int                    scans_in_flight
);

   typedef struct packed {
      logic [SegWidth-1:0] thousands;
      logic [SegWidth-1:0] hundreds;
      logic [SegWidth-1:0] tens;
      logic [SegWidth-1:0] units;
      logic                buzzer;
      logic                adjusting;
   } display_type;

   // Glyphs for digits 9 down to 0; digit 0 sits in the low bits
   localparam logic [10*SegWidth-1:0] GlyphTable = {
      7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
   };

   logic [CountWidth-1:0] default_reg;
   logic [CountWidth-1:0] setpoint;
   logic [CountWidth-1:0] edit_count;
   logic                  in_adjust;
   logic                  alarm;
   display_type           display_q[$];
   int                    result_number;

   function automatic logic [SegWidth-1:0] glyph(input int digit);
      return GlyphTable[digit*SegWidth +: SegWidth];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [SegWidth-1:0] got,
                              input logic [SegWidth-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s got 0x%0h, expected 0x%0h",
                                   result_number, name, got, want));
      end
   endtask

   // Advance the mode, count and alarm by one scan and build its display word
   task automatic predict_display(input logic [7:0] sample, input logic set_b,
                                  input logic inc_b, input logic dec_b,
                                  input logic restore_b, output display_type word);
      int shown;
      int temperature;
      temperature = (int'(sample) * 488) / 1000;
      if (!in_adjust) begin
         shown = temperature;
         alarm = (temperature >= int'(setpoint));
         if (set_b) in_adjust = 1'b1;
      end else begin
         if (inc_b) begin
            if (edit_count < CountMax) edit_count = edit_count + CountWidth'(1);
         end else if (dec_b) begin
            if (edit_count != '0) edit_count = edit_count - CountWidth'(1);
         end else if (restore_b) begin
            setpoint   = (default_reg > CountMax) ? CountMax : default_reg;
            edit_count = setpoint;
         end
         shown = int'(edit_count);
         if (set_b) begin
            setpoint  = edit_count;
            in_adjust = 1'b0;
         end
      end
      word.thousands = glyph((shown / 1000) % 10);
      word.hundreds  = glyph((shown / 100) % 10);
      word.tens      = glyph((shown / 10) % 10);
      word.units     = glyph(shown % 10);
      word.buzzer    = alarm;
      word.adjusting = in_adjust;
   endtask

   always @(posedge clock) begin
      display_type want;
      display_type fresh;
      if (reset) begin
         default_reg     = DefaultReset;
         setpoint        = DefaultReset;
         edit_count      = DefaultReset;
         in_adjust       = 1'b0;
         alarm           = 1'b0;
         result_number   = 0;
         mismatches      = 0;
         display_q.delete();
         scans_in_flight <= 0;
      end else begin
         // retire the returned word first: it never belongs to a scan taken now
         if (rsp_valid && rsp_ready) begin
            if (display_q.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with no scan waiting",
                                         result_number));
            end else begin
               want = display_q.pop_front();
               check_field("seg_thousands", rsp_seg_thousands, want.thousands);
               check_field("seg_hundreds", rsp_seg_hundreds, want.hundreds);
               check_field("seg_tens", rsp_seg_tens, want.tens);
               check_field("seg_units", rsp_seg_units, want.units);
               check_field("buzzer_on", SegWidth'(rsp_buzzer_on),
                           SegWidth'(want.buzzer));
               check_field("adjusting", SegWidth'(rsp_adjusting),
                           SegWidth'(want.adjusting));
            end
            result_number++;
         end
         if (csr_valid && csr_ready) default_reg = csr_default_setpoint;
         if (req_valid && req_ready) begin
            predict_display(req_adc_sample, req_set_pressed, req_inc_pressed,
                            req_dec_pressed, req_restore_pressed, fresh);
            display_q.push_back(fresh);
         end
         scans_in_flight <= display_q.size();
      end
   end

endmodule

>>> dv/overheat_alarm_with_setpoint_tb.sv
// ----------------------------------------------------------------------------
// overheat_alarm_with_setpoint_tb: testbench top of the overheat alarm
// Drives directed and random scans and default-setpoint writes under varying
// back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module overheat_alarm_with_setpoint_tb
   import ovha_pkg::*;
();

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_adc_sample = '0;
   logic                  req_set_pressed = 1'b0;
   logic                  req_inc_pressed = 1'b0;
   logic                  req_dec_pressed = 1'b0;
   logic                  req_restore_pressed = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SegWidth-1:0]   rsp_seg_thousands;
   logic [SegWidth-1:0]   rsp_seg_hundreds;
   logic [SegWidth-1:0]   rsp_seg_tens;
   logic [SegWidth-1:0]   rsp_seg_units;
   logic                  rsp_buzzer_on;
   logic                  rsp_adjusting;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CountWidth-1:0] csr_default_setpoint = '0;

   int mismatches;
   int scans_in_flight;

   // Percent of cycles in which each side holds off
   int sender_idle_pct   = 23;
   int receiver_idle_pct = 65;

   overheat_alarm_with_setpoint dut (.*);

   overheat_alarm_with_setpoint_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: end the run if the block hangs
   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   // Stall the display side at random; a zero percentage keeps ready high
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Offer one scan word and hold it until the block takes it. Valid stays high
   // on return, so a back-to-back word needs no drop in between.
   task automatic send_scan(input logic [7:0] sample, input logic set_b,
                            input logic inc_b, input logic dec_b,
                            input logic restore_b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_adc_sample      <= sample;
      req_set_pressed     <= set_b;
      req_inc_pressed     <= inc_b;
      req_dec_pressed     <= dec_b;
      req_restore_pressed <= restore_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scans_in_flight != 0) @(posedge clock);
   endtask

   // Write the default setpoint while the block is idle
   task automatic write_default(input logic [CountWidth-1:0] value);
      wait_for_results();
      csr_valid            <= 1'b1;
      csr_default_setpoint <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random scans shaped as monitor stretches that end in a set press,
   // followed by edit stretches that end in a set press. A few stray set
   // presses knock the pattern out of step now and then.
   task automatic run_scans(input int quota);
      int   sent;
      int   span;
      int   pick;
      logic set_b;
      logic inc_b;
      logic dec_b;
      logic restore_b;
      sent = 0;
      while (sent < quota) begin
         span = $urandom_range(1, 12);
         for (int i = 0; i < span && sent < quota; i++) begin
            set_b = (i == span - 1) || ($urandom_range(0, 19) == 0);
            // edit buttons are noise while monitoring
            send_scan(8'($urandom_range(0, 255)), set_b, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end
         span = $urandom_range(1, 16);
         for (int i = 0; i < span && sent < quota; i++) begin
            pick      = $urandom_range(0, 9);
            inc_b     = (pick <= 3);
            dec_b     = (pick >= 4 && pick <= 6);
            restore_b = (pick == 7);
            if (pick == 8) begin
               // overlapping presses exercise the priority order
               inc_b     = 1'($urandom_range(0, 1));
               dec_b     = 1'($urandom_range(0, 1));
               restore_b = 1'($urandom_range(0, 1));
            end
            set_b = (i == span - 1) || ($urandom_range(0, 19) == 0);
            send_scan(8'($urandom_range(0, 255)), set_b, inc_b, dec_b, restore_b);
            sent++;
         end
      end
   endtask

   // Mostly setpoints near the temperature range so the alarm toggles,
   // with the extremes and the above-range values mixed in
   function automatic logic [CountWidth-1:0] pick_default();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return CountWidth'($urandom_range(0, 130));
      if (pick == 6) return '0;
      if (pick == 7) return CountMax;
      if (pick == 8) return '1;
      return CountWidth'($urandom_range(0, 16383));
   endfunction

   initial begin
      int waited;
      @(posedge clock);
      while (reset) @(posedge clock);

      // Monitor scans with the reset default of 35: range ends and the
      // threshold edge (sample 71 gives 34, sample 72 gives 35)
      send_scan(8'd0,   1'b0, 1'b0, 1'b0, 1'b0);
      send_scan(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
      send_scan(8'd71,  1'b0, 1'b0, 1'b0, 1'b0);
      send_scan(8'd72,  1'b0, 1'b0, 1'b0, 1'b0);
      // edit buttons do nothing in monitor mode; set enters adjust
      send_scan(8'd128, 1'b0, 1'b1, 1'b1, 1'b1);
      send_scan(8'd1,   1'b1, 1'b0, 1'b0, 1'b0);
      // inc wins over dec and restore, then dec wins over restore
      send_scan(8'd170, 1'b0, 1'b1, 1'b1, 1'b1);
      send_scan(8'd85,  1'b0, 1'b0, 1'b1, 1'b1);
      send_scan(8'd0,   1'b0, 1'b0, 1'b0, 1'b1);
      // set stores the count after the inc applies
      send_scan(8'd255, 1'b1, 1'b1, 1'b0, 1'b0);
      send_scan(8'd73,  1'b0, 1'b0, 1'b0, 1'b0);

      // Zero default: dec holds at the floor, setpoint 0 alarms at 0 degrees
      write_default('0);
      send_scan(8'd255, 1'b1, 1'b0, 1'b0, 1'b0);
      send_scan(8'd0,   1'b0, 1'b0, 1'b0, 1'b1);
      send_scan(8'd0,   1'b0, 1'b0, 1'b1, 1'b0);
      send_scan(8'd0,   1'b1, 1'b0, 1'b0, 1'b0);
      send_scan(8'd0,   1'b0, 1'b0, 1'b0, 1'b0);

      // Default above range loads as 9999; inc holds at the ceiling
      write_default('1);
      send_scan(8'd255, 1'b1, 1'b0, 1'b0, 1'b0);
      send_scan(8'd0,   1'b0, 1'b0, 1'b0, 1'b1);
      send_scan(8'd0,   1'b0, 1'b1, 1'b0, 1'b0);
      send_scan(8'd0,   1'b0, 1'b0, 1'b1, 1'b0);
      send_scan(8'd0,   1'b1, 1'b1, 1'b0, 1'b0);
      send_scan(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);

      // A new default leaves setpoint and count alone until restore
      write_default(CountMax);
      send_scan(8'd255, 1'b1, 1'b0, 1'b0, 1'b0);
      send_scan(8'd255, 1'b1, 1'b0, 1'b1, 1'b0);

      // Random part: three back-pressure profiles, three defaults each,
      // with a full drain halfway through every stretch
      for (int profile = 0; profile < 3; profile++) begin
         sender_idle_pct   = (profile == 0) ? 23 : (profile == 1) ? 65 : 0;
         receiver_idle_pct = (profile == 0) ? 65 : (profile == 1) ? 23 : 0;
         for (int stretch = 0; stretch < 3; stretch++) begin
            write_default(pick_default());
            run_scans(53);
            wait_for_results();
            run_scans(53);
         end
      end

      // Drain, then allow the pipeline to show any stray word
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (scans_in_flight != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);

      if (mismatches == 0 && scans_in_flight == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
